>>> rtl/vpcc_pkg.sv
// Shared types and constants for the virtio PCI common configuration block.
// Holds the register map, request codes and the request/response structs.
// No dependencies.
`default_nettype none

package vpcc_pkg;

    // Queue table depth and the bits needed to index it
    localparam int NUM_QUEUES = 8;
    localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int RING_CNT   = 3;
    localparam int RING_W     = $clog2(RING_CNT);

    // Field widths
    localparam int OFF_W    = 6;
    localparam int DATA_W   = 64;
    localparam int MAXQ_W   = 16;
    localparam int VCNT_W   = 12;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [63:0] OFFERED_FEATURES_RST = 64'h0000_0001_0000_0000;
    localparam logic [15:0] MAX_QUEUE_SIZE_RST   = 16'd256;
    localparam logic [11:0] VECTOR_COUNT_RST     = 12'd2;
    localparam logic [15:0] NO_VECTOR            = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFERED_FEATURES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUE_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT     = 2'd2;

    // Common window offsets
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT_SEL = 6'h00;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT     = 6'h04;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT_SEL = 6'h08;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT     = 6'h0c;
    localparam logic [OFF_W-1:0] OFF_CFG_VECTOR   = 6'h10;
    localparam logic [OFF_W-1:0] OFF_NUM_QUEUES   = 6'h12;
    localparam logic [OFF_W-1:0] OFF_STATUS       = 6'h14;
    localparam logic [OFF_W-1:0] OFF_CFG_GEN      = 6'h15;
    localparam logic [OFF_W-1:0] OFF_QUEUE_SEL    = 6'h16;
    localparam logic [OFF_W-1:0] OFF_QUEUE_SIZE   = 6'h18;
    localparam logic [OFF_W-1:0] OFF_QUEUE_VECTOR = 6'h1a;
    localparam logic [OFF_W-1:0] OFF_QUEUE_ENABLE = 6'h1c;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NOTIFY = 6'h1e;

    // Access widths (log2 bytes)
    localparam logic [1:0] AW_BYTE = 2'd0;
    localparam logic [1:0] AW_HALF = 2'd1;
    localparam logic [1:0] AW_WORD = 2'd2;
    localparam logic [1:0] AW_DBL  = 2'd3;

    typedef enum logic [2:0] {
        REQ_READ     = 3'd0,
        REQ_WRITE    = 3'd1,
        REQ_DOORBELL = 3'd2,
        REQ_ISR_READ = 3'd3,
        REQ_RAISE    = 3'd4
    } req_type_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [OFF_W-1:0]  reg_offset;
        logic [1:0]        access_width;
        logic [DATA_W-1:0] write_data;
    } vpcc_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_error;
        logic              doorbell_valid;
        logic [15:0]       doorbell_queue;
        logic              irq_pending;
    } vpcc_rsp_t;

    typedef struct packed {
        logic [63:0]       offered_features;
        logic [MAXQ_W-1:0] max_queue_size;
        logic [VCNT_W-1:0] vector_count;
    } vpcc_cfg_t;

    // Scalar register width: {known, log2 bytes}
    function automatic logic [2:0] reg_width(input logic [OFF_W-1:0] off);
        logic [2:0] res;
        res = 3'b000;
        case (off)
            OFF_DEV_FEAT_SEL, OFF_DEV_FEAT, OFF_DRV_FEAT_SEL, OFF_DRV_FEAT:
                res = {1'b1, AW_WORD};
            OFF_CFG_VECTOR, OFF_NUM_QUEUES, OFF_QUEUE_SEL, OFF_QUEUE_SIZE,
            OFF_QUEUE_VECTOR, OFF_QUEUE_ENABLE, OFF_QUEUE_NOTIFY:
                res = {1'b1, AW_HALF};
            OFF_STATUS, OFF_CFG_GEN:
                res = {1'b1, AW_BYTE};
            default:
                res = 3'b000;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/virtio_pci_common_config_regs_unit.sv
// Virtio PCI common configuration window: stream request in, response out.
// An accepted request passes the request register, then the response register.
// Throughput: one request per cycle; a held response stalls intake only once
// the request register is also full.
// Reset (aresetn low, synchronous) empties both stages and restores the
// configuration registers and the whole register file to their reset values.
`default_nettype none

module virtio_pci_common_config_regs_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    // Request channel
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: reg_offset[5:0], access_width[7:6], write_data[71:8]
    input  wire logic [71:0]  s_axis_tdata,
    // tuser: req_type[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    // Response channel
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: read_data[63:0], access_error[64], doorbell_valid[65],
    //        doorbell_queue[81:66], irq_pending[82], zero[87:83]
    output logic [87:0]       m_axis_tdata
);
    import vpcc_pkg::*;

    vpcc_cfg_t cfg_reg;
    vpcc_req_t in_req_reg;
    logic      in_vld_reg;
    vpcc_rsp_t out_rsp_reg;
    logic      out_vld_reg;
    vpcc_rsp_t rsp;
    logic      s_fire;
    logic      advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offered_features <= OFFERED_FEATURES_RST;
            cfg_reg.max_queue_size   <= MAX_QUEUE_SIZE_RST;
            cfg_reg.vector_count     <= VECTOR_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OFFERED_FEATURES: cfg_reg.offered_features <= cfg_wdata;
                CFG_MAX_QUEUE_SIZE:   cfg_reg.max_queue_size   <= cfg_wdata[MAXQ_W-1:0];
                CFG_VECTOR_COUNT:     cfg_reg.vector_count     <= cfg_wdata[VCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Move the request into the response register when there is room
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg.req_type     <= s_axis_tuser;
            in_req_reg.reg_offset   <= s_axis_tdata[5:0];
            in_req_reg.access_width <= s_axis_tdata[7:6];
            in_req_reg.write_data   <= s_axis_tdata[71:8];
        end
    end

    vpcc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (in_req_reg),
        .req_fire (advance),
        .cfg      (cfg_reg),
        .rsp      (rsp)
    );

    // Response register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_rsp_reg.irq_pending, out_rsp_reg.doorbell_queue,
                            out_rsp_reg.doorbell_valid, out_rsp_reg.access_error,
                            out_rsp_reg.read_data};

    // A doorbell only ever names a queue that exists
    a_db_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_rsp_reg.doorbell_valid)
            |-> (out_rsp_reg.doorbell_queue < 16'(NUM_QUEUES)))
        else $error("doorbell names a queue beyond the table");

    // A failed access returns no data and rings no doorbell
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_rsp_reg.access_error)
            |-> (out_rsp_reg.read_data == '0 && !out_rsp_reg.doorbell_valid))
        else $error("error response carries data or a doorbell");

    // An empty stage always leaves room for a new request
    a_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_vld_reg || !out_vld_reg) |-> s_axis_tready)
        else $error("intake stalled with a free stage");

    // A request held at a stalled output stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_axis_tready) |=> in_vld_reg)
        else $error("request lost while the output was stalled");

endmodule

`default_nettype wire

>>> rtl/vpcc_core.sv
// Register file and access decode of the virtio common configuration window.
// Computes the response of one request and commits state when it advances.
// Depends on vpcc_pkg.
`default_nettype none

module vpcc_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire vpcc_pkg::vpcc_req_t req,
    input  wire logic               req_fire,
    input  wire vpcc_pkg::vpcc_cfg_t cfg,
    output vpcc_pkg::vpcc_rsp_t     rsp
);
    import vpcc_pkg::*;

    logic [31:0] dev_win_reg, dev_win_next;
    logic [31:0] drv_win_reg, drv_win_next;
    logic [63:0] acc_feat_reg, acc_feat_next;
    logic [15:0] cfg_vec_reg, cfg_vec_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] sel_q_reg, sel_q_next;
    logic [15:0] q_len_reg [NUM_QUEUES];
    logic [15:0] q_len_next [NUM_QUEUES];
    logic [15:0] q_vec_reg [NUM_QUEUES];
    logic [15:0] q_vec_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] q_on_reg, q_on_next;
    logic [63:0] ring_reg [NUM_QUEUES][RING_CNT];
    logic [63:0] ring_next [NUM_QUEUES][RING_CNT];
    logic [1:0]  isr_reg, isr_next;

    logic              qok;
    logic [QIDX_W-1:0] q;
    logic [OFF_W-1:0]  off;
    logic [1:0]        aw;
    logic [63:0]       wmask;
    logic [63:0]       wdata;
    logic              is_ring;
    logic [RING_W-1:0] rsel;
    logic [63:0]       ring_full;
    logic              ring_dbl;
    logic              ring_half;
    logic [2:0]        sw;
    logic              scalar_ok;
    logic [15:0]       q_len_clip;
    logic [15:0]       vec_checked;
    logic [15:0]       qsize_sat;
    logic [15:0]       db_q;
    logic [63:0]       rd;
    logic              err;
    logic              dvalid;
    logic [15:0]       dq;

    // Decode the selected queue and the access
    always_comb begin
        qok   = sel_q_reg < 16'(NUM_QUEUES);
        q     = qok ? sel_q_reg[QIDX_W-1:0] : '0;
        off   = req.reg_offset;
        aw    = req.access_width;
        case (aw)
            AW_BYTE: wmask = 64'h0000_0000_0000_00FF;
            AW_HALF: wmask = 64'h0000_0000_0000_FFFF;
            AW_WORD: wmask = 64'h0000_0000_FFFF_FFFF;
            default: wmask = '1;
        endcase
        wdata     = req.write_data & wmask;
        is_ring   = off[5] && (off[4:3] != 2'b11);
        rsel      = off[4:3];
        ring_full = '0;
        if (is_ring && qok) begin
            ring_full = ring_reg[q][rsel];
        end
        ring_dbl  = (aw == AW_DBL) && (off[2:0] == 3'b000);
        ring_half = (aw == AW_WORD) && (off[1:0] == 2'b00);
        sw        = reg_width(off);
        scalar_ok = sw[2] && (sw[1:0] == aw);
        q_len_clip = (q_len_reg[q] < cfg.max_queue_size) ? q_len_reg[q]
                                                         : cfg.max_queue_size;
        vec_checked = (wdata[15:0] < {4'b0, cfg.vector_count}) ? wdata[15:0]
                                                                : NO_VECTOR;
        qsize_sat = (wdata > {48'b0, cfg.max_queue_size}) ? cfg.max_queue_size
                                                          : wdata[15:0];
        db_q = req.write_data[15:0];
    end

    // Evaluate the request and build the next state
    always_comb begin
        dev_win_next  = dev_win_reg;
        drv_win_next  = drv_win_reg;
        acc_feat_next = acc_feat_reg;
        cfg_vec_next  = cfg_vec_reg;
        status_next   = status_reg;
        sel_q_next    = sel_q_reg;
        q_len_next    = q_len_reg;
        q_vec_next    = q_vec_reg;
        q_on_next     = q_on_reg;
        ring_next     = ring_reg;
        isr_next      = isr_reg;
        rd     = '0;
        err    = 1'b0;
        dvalid = 1'b0;
        dq     = '0;

        unique case (req_type_t'(req.req_type))
            REQ_READ: begin
                if (is_ring) begin
                    if (ring_dbl) begin
                        rd = ring_full;
                    end else if (ring_half) begin
                        rd = off[2] ? {32'b0, ring_full[63:32]} : {32'b0, ring_full[31:0]};
                    end else begin
                        err = 1'b1;
                    end
                end else if (!scalar_ok) begin
                    err = 1'b1;
                end else begin
                    case (off)
                        OFF_DEV_FEAT_SEL: rd = {32'b0, dev_win_reg};
                        OFF_DEV_FEAT: begin
                            if (dev_win_reg == 32'd0) begin
                                rd = {32'b0, cfg.offered_features[31:0]};
                            end else if (dev_win_reg == 32'd1) begin
                                rd = {32'b0, cfg.offered_features[63:32]};
                            end
                        end
                        OFF_DRV_FEAT_SEL: rd = {32'b0, drv_win_reg};
                        OFF_DRV_FEAT: begin
                            if (drv_win_reg == 32'd0) begin
                                rd = {32'b0, acc_feat_reg[31:0]};
                            end else if (drv_win_reg == 32'd1) begin
                                rd = {32'b0, acc_feat_reg[63:32]};
                            end
                        end
                        OFF_CFG_VECTOR: rd = {48'b0, cfg_vec_reg};
                        OFF_NUM_QUEUES: rd = 64'(NUM_QUEUES);
                        OFF_STATUS:     rd = {56'b0, status_reg};
                        OFF_QUEUE_SEL:  rd = {48'b0, sel_q_reg};
                        OFF_QUEUE_SIZE: begin
                            if (qok && (cfg.max_queue_size != '0)) begin
                                rd = {48'b0, q_len_clip};
                            end
                        end
                        OFF_QUEUE_VECTOR: rd = qok ? {48'b0, q_vec_reg[q]} : {48'b0, NO_VECTOR};
                        OFF_QUEUE_ENABLE: rd = {63'b0, qok && q_on_reg[q]};
                        default:          rd = '0;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (is_ring) begin
                    if (ring_dbl) begin
                        if (qok) begin
                            ring_next[q][rsel] = wdata;
                        end
                    end else if (ring_half) begin
                        if (qok) begin
                            if (off[2]) begin
                                ring_next[q][rsel][63:32] = wdata[31:0];
                            end else begin
                                ring_next[q][rsel][31:0] = wdata[31:0];
                            end
                        end
                    end else begin
                        err = 1'b1;
                    end
                end else if (!scalar_ok) begin
                    err = 1'b1;
                end else begin
                    case (off)
                        OFF_DEV_FEAT_SEL: dev_win_next = wdata[31:0];
                        OFF_DRV_FEAT_SEL: drv_win_next = wdata[31:0];
                        OFF_DRV_FEAT: begin
                            if (drv_win_reg == 32'd0) begin
                                acc_feat_next[31:0] = wdata[31:0];
                            end else if (drv_win_reg == 32'd1) begin
                                acc_feat_next[63:32] = wdata[31:0];
                            end
                        end
                        OFF_CFG_VECTOR: cfg_vec_next = vec_checked;
                        OFF_STATUS: begin
                            if (wdata[7:0] == 8'd0) begin
                                // Device reset: drop all driver-visible state
                                dev_win_next  = '0;
                                drv_win_next  = '0;
                                acc_feat_next = '0;
                                cfg_vec_next  = NO_VECTOR;
                                status_next   = '0;
                                sel_q_next    = '0;
                                q_on_next     = '0;
                                isr_next      = '0;
                                for (int i = 0; i < NUM_QUEUES; i++) begin
                                    q_len_next[i] = cfg.max_queue_size;
                                    q_vec_next[i] = NO_VECTOR;
                                    for (int j = 0; j < RING_CNT; j++) begin
                                        ring_next[i][j] = '0;
                                    end
                                end
                            end else begin
                                status_next = wdata[7:0];
                            end
                        end
                        OFF_QUEUE_SEL: sel_q_next = wdata[15:0];
                        OFF_QUEUE_SIZE: begin
                            if (qok) begin
                                q_len_next[q] = qsize_sat;
                            end
                        end
                        OFF_QUEUE_VECTOR: begin
                            if (qok) begin
                                q_vec_next[q] = vec_checked;
                            end
                        end
                        OFF_QUEUE_ENABLE: begin
                            if (qok) begin
                                q_on_next[q] = wdata[0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            REQ_DOORBELL: begin
                if ((db_q < 16'(NUM_QUEUES)) && q_on_reg[db_q[QIDX_W-1:0]]) begin
                    dvalid = 1'b1;
                    dq     = db_q;
                end
            end
            REQ_ISR_READ: begin
                rd       = {62'b0, isr_reg};
                isr_next = '0;
            end
            REQ_RAISE: begin
                isr_next = isr_reg | req.write_data[1:0];
            end
            default: begin
                err = 1'b1;
            end
        endcase

        rsp.read_data      = rd;
        rsp.access_error   = err;
        rsp.doorbell_valid = dvalid;
        rsp.doorbell_queue = dq;
        rsp.irq_pending    = (isr_next != 2'b00);
    end

    // Commit state when the request advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_win_reg  <= '0;
            drv_win_reg  <= '0;
            acc_feat_reg <= '0;
            cfg_vec_reg  <= NO_VECTOR;
            status_reg   <= '0;
            sel_q_reg    <= '0;
            q_on_reg     <= '0;
            isr_reg      <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                q_len_reg[i] <= MAX_QUEUE_SIZE_RST;
                q_vec_reg[i] <= NO_VECTOR;
                for (int j = 0; j < RING_CNT; j++) begin
                    ring_reg[i][j] <= '0;
                end
            end
        end else if (req_fire) begin
            dev_win_reg  <= dev_win_next;
            drv_win_reg  <= drv_win_next;
            acc_feat_reg <= acc_feat_next;
            cfg_vec_reg  <= cfg_vec_next;
            status_reg   <= status_next;
            sel_q_reg    <= sel_q_next;
            q_on_reg     <= q_on_next;
            isr_reg      <= isr_next;
            q_len_reg    <= q_len_next;
            q_vec_reg    <= q_vec_next;
            ring_reg     <= ring_next;
        end
    end

endmodule

`default_nettype wire
